// ----- rtl/hermite_expansion_coefficients_macros.svh -----
// assertion macros for the hermite expansion coefficient block
// no dependencies
`ifndef HERMITE_EXPANSION_COEFFICIENTS_MACROS_SVH
`define HERMITE_EXPANSION_COEFFICIENTS_MACROS_SVH

// implication checked on every clock edge outside reset
`define HEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hec assertion failed");

// next-cycle implication checked outside reset
`define HEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hec assertion failed");

`endif

// ----- rtl/hec_pkg.sv -----
// package for the hermite expansion coefficient block
// constants, types and fixed-point helpers; no dependencies
package hec_pkg;
    localparam int MAX_POWER = 6;
    localparam int FRAC_BITS = 40;
    localparam int DEPTH = 2 * MAX_POWER + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PW_W = $clog2(MAX_POWER + 1);

    typedef logic signed [63:0] fix_t;

    localparam fix_t SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fix_t SMIN = 64'sh8000_0000_0000_0000;
    localparam fix_t ONE = fix_t'(64'sd1 <<< FRAC_BITS);

    function automatic fix_t sat_add(input fix_t a, input fix_t b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                sat_add = s[64] ? SMIN : SMAX;
            else
                sat_add = s[63:0];
        end
    endfunction

    // saturate a 128-bit signed value to 64 bits
    function automatic fix_t sat128(input logic signed [127:0] v);
        begin
            if (v > 128'sh7FFF_FFFF_FFFF_FFFF)
                sat128 = SMAX;
            else if (v < -128'sh8000_0000_0000_0000)
                sat128 = SMIN;
            else
                sat128 = v[63:0];
        end
    endfunction
endpackage

// ----- rtl/hermite_expansion_coefficients.sv -----
// top level of the hermite expansion coefficient block
// depends on hec_pkg and hermite_expansion_coefficients_macros.svh
//
// usage: drive power_a, power_b, offset_a, offset_b and half_inv_exp and
// raise start while busy is low; that transaction is accepted at the edge.
// busy stays high until all coefficients of the transaction are out.
// results come out lowest index first, one per valid strobe, each held for
// one cycle only; last_coef marks the top index. the receiver cannot stall.
// each term goes through one shared multiplier as four 32x32 partial
// products, in the steps read, operand, multiply and accumulate;
// a skipped edge term takes only the read step and each coefficient ends
// with a write. a transaction clears the store, runs n2 passes over top
// index n2, then n1 passes over top index n = n1+n2, each with a copy back,
// computes the top power when n > 0 and then strobes the results, the
// last one in the final busy cycle. the next transaction can be started
// once busy has fallen.
// reset clears the control state; the stores need no clearing since each
// transaction writes every entry it reads before reading it.
module hermite_expansion_coefficients (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      power_a,
    input  logic [2:0]                      power_b,
    input  logic signed [63:0]              offset_a,
    input  logic signed [63:0]              offset_b,
    input  logic signed [63:0]              half_inv_exp,
    output logic                            valid,
    output logic [3:0]                      coef_index,
    output logic signed [63:0]              coef_value,
    output logic                            last_coef
);
    import hec_pkg::*;
    `include "hermite_expansion_coefficients_macros.svh"

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_TERM  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_ACC   = 11'b00000100000,
        S_WR    = 11'b00001000000,
        S_COPY  = 11'b00010000000,
        S_TOP   = 11'b00100000000,
        S_OUTRD = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    fix_t coef_mem [DEPTH];
    fix_t next_mem [DEPTH];
    fix_t coef_rd_reg, next_rd_reg;
    logic [IDX_W-1:0] coef_ra, next_ra, coef_wa, next_wa;
    logic coef_we, next_we;
    fix_t coef_wd, next_wd;

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_wa] <= coef_wd;
        coef_rd_reg <= coef_mem[coef_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_rd_reg <= next_mem[next_ra];
    end

    // item registers
    logic [PW_W-1:0] n1_reg, n2_reg;
    logic [IDX_W-1:0] n_reg, m_reg, t_reg;
    logic [PW_W-1:0] pass_reg;
    logic phase_a_reg;
    fix_t xa_reg, xb_reg, p_reg, acc_reg, top_reg;
    logic [1:0] term_reg;
    logic [1:0] pp_reg;
    fix_t mop_a_reg, mop_b_reg;
    logic signed [127:0] prod_reg;
    logic mul_int_reg;
    logic [IDX_W-1:0] topcnt_reg;

    logic [PW_W-1:0] pa_sat, pb_sat;
    assign pa_sat = (power_a > 3'(MAX_POWER)) ? PW_W'(MAX_POWER) : power_a[PW_W-1:0];
    assign pb_sat = (power_b > 3'(MAX_POWER)) ? PW_W'(MAX_POWER) : power_b[PW_W-1:0];

    // shared multiplier: magnitudes split in 32-bit halves, one partial a cycle
    logic [63:0] mag_a, mag_b;
    logic neg_ab;
    logic [31:0] pa_half, pb_half;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    assign mag_a = mop_a_reg[63] ? (~mop_a_reg + 64'd1) : mop_a_reg;
    assign mag_b = mop_b_reg[63] ? (~mop_b_reg + 64'd1) : mop_b_reg;
    assign neg_ab = mop_a_reg[63] ^ mop_b_reg[63];
    assign pa_half = pp_reg[0] ? mag_a[63:32] : mag_a[31:0];
    assign pb_half = pp_reg[1] ? mag_b[63:32] : mag_b[31:0];
    assign pp = pa_half * pb_half;
    assign pp_sh = {64'd0, pp} << (7'(pp_reg[0]) * 7'd32 + 7'(pp_reg[1]) * 7'd32);

    logic signed [127:0] prod_s, prod_r;
    fix_t mul_res;
    assign prod_s = neg_ab ? -prod_reg : prod_reg;
    assign prod_r = mul_int_reg ? prod_s
                  : ((prod_s + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    assign mul_res = sat128(prod_r);

    fix_t x_cur;
    assign x_cur = phase_a_reg ? xa_reg : xb_reg;

    // term t: 0 = x*e[t], 1 = p*e[t-1], 2 = (t+1)*e[t+1]
    logic term_skip;
    always_comb
    begin
        unique case (term_reg)
            2'd1: term_skip = (t_reg == '0);
            2'd2: term_skip = (t_reg == m_reg);
            default: term_skip = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (term_reg)
            2'd1: coef_ra = t_reg - IDX_W'(1);
            2'd2: coef_ra = t_reg + IDX_W'(1);
            default: coef_ra = t_reg;
        endcase
        if (state_reg == S_OUTRD || state_reg == S_COPY)
            coef_ra = t_reg;
    end

    always_comb
    begin
        next_ra = t_reg;
        coef_we = 1'b0;
        coef_wa = t_reg;
        coef_wd = next_rd_reg;
        next_we = 1'b0;
        next_wa = t_reg;
        next_wd = acc_reg;
        if (state_reg == S_INIT)
        begin
            coef_we = 1'b1;
            coef_wd = (t_reg == '0) ? ONE : '0;
        end
        if (state_reg == S_WR)
            next_we = 1'b1;
        if (state_reg == S_COPY && pp_reg[0])
            coef_we = 1'b1;
    end

    logic last_t;
    assign last_t = (t_reg == m_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_INIT;
            S_INIT:
                if (t_reg == IDX_W'(DEPTH - 1))
                    state_next = (n_reg == '0) ? S_OUTRD
                               : ((n2_reg == '0) && (n1_reg == '0)) ? S_OUTRD : S_RD;
            S_RD:
                state_next = term_skip ? ((term_reg == 2'd2) ? S_WR : S_RD) : S_TERM;
            S_TERM:
                state_next = S_MUL;
            S_MUL:
                if (pp_reg == 2'd3)
                    state_next = (topcnt_reg != '0) ? S_TOP : S_ACC;
            S_ACC:
                state_next = (term_reg == 2'd2) ? S_WR : S_RD;
            S_WR:
                state_next = last_t ? S_COPY : S_RD;
            S_COPY:
                if (pp_reg[0] && last_t)
                    state_next = ((pass_reg == PW_W'(1)) && phase_a_reg) ? S_TOP : S_RD;
            S_TOP:
                state_next = (topcnt_reg == n_reg) ? S_OUTRD : S_MUL;
            S_OUTRD:
                state_next = S_OUT;
            S_OUT:
                state_next = (t_reg == n_reg) ? S_IDLE : S_OUTRD;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                t_reg <= '0;
                topcnt_reg <= '0;
                if (pa_sat < pb_sat)
                begin
                    n1_reg <= pb_sat;
                    n2_reg <= pa_sat;
                    xa_reg <= offset_b;
                    xb_reg <= offset_a;
                end
                else
                begin
                    n1_reg <= pa_sat;
                    n2_reg <= pb_sat;
                    xa_reg <= offset_a;
                    xb_reg <= offset_b;
                end
                n_reg <= IDX_W'(pa_sat) + IDX_W'(pb_sat);
                p_reg <= half_inv_exp;
                top_reg <= ONE;
            end
            S_INIT:
            begin
                if (t_reg == IDX_W'(DEPTH - 1))
                begin
                    t_reg <= '0;
                    term_reg <= 2'd0;
                    acc_reg <= '0;
                    pp_reg <= 2'd0;
                    if (n2_reg != '0)
                    begin
                        phase_a_reg <= 1'b0;
                        m_reg <= IDX_W'(n2_reg);
                        pass_reg <= n2_reg;
                    end
                    else
                    begin
                        phase_a_reg <= 1'b1;
                        m_reg <= n_reg;
                        pass_reg <= n1_reg;
                    end
                end
                else
                    t_reg <= t_reg + IDX_W'(1);
            end
            S_RD:
                if (term_skip)
                    term_reg <= term_reg + 2'd1;
            S_TERM:
            begin
                unique case (term_reg)
                    2'd0: mop_a_reg <= x_cur;
                    2'd1: mop_a_reg <= p_reg;
                    default: mop_a_reg <= fix_t'(t_reg) + fix_t'(1);
                endcase
                mul_int_reg <= (term_reg == 2'd2);
                mop_b_reg <= coef_rd_reg;
                prod_reg <= '0;
                pp_reg <= 2'd0;
            end
            S_MUL:
            begin
                prod_reg <= prod_reg + pp_sh;
                pp_reg <= pp_reg + 2'd1;
            end
            S_ACC:
            begin
                acc_reg <= (term_reg == 2'd0) ? mul_res : sat_add(acc_reg, mul_res);
                term_reg <= term_reg + 2'd1;
            end
            S_WR:
            begin
                term_reg <= 2'd0;
                if (last_t)
                begin
                    t_reg <= '0;
                    pp_reg <= 2'd0;
                end
                else
                    t_reg <= t_reg + IDX_W'(1);
            end
            S_COPY:
            begin
                pp_reg[0] <= ~pp_reg[0];
                if (pp_reg[0])
                begin
                    if (last_t)
                    begin
                        t_reg <= '0;
                        if (pass_reg == PW_W'(1))
                        begin
                            if (!phase_a_reg)
                            begin
                                phase_a_reg <= 1'b1;
                                m_reg <= n_reg;
                                pass_reg <= n1_reg;
                            end
                            else
                            begin
                                top_reg <= p_reg;
                                topcnt_reg <= IDX_W'(1);
                            end
                        end
                        else
                            pass_reg <= pass_reg - PW_W'(1);
                    end
                    else
                        t_reg <= t_reg + IDX_W'(1);
                end
            end
            S_TOP:
            begin
                if (topcnt_reg == IDX_W'(1))
                    top_reg <= p_reg;
                else
                    top_reg <= mul_res;
                mop_a_reg <= (topcnt_reg == IDX_W'(1)) ? p_reg : mul_res;
                mop_b_reg <= p_reg;
                mul_int_reg <= 1'b0;
                prod_reg <= '0;
                pp_reg <= 2'd0;
                topcnt_reg <= topcnt_reg + IDX_W'(1);
                if (topcnt_reg == n_reg)
                    t_reg <= '0;
            end
            S_OUTRD:
                ;
            S_OUT:
                t_reg <= t_reg + IDX_W'(1);
            default:
                ;
        endcase
    end

    // each pass above leaves next_mem holding its results; copy
    // reads next_mem at t in the first half-step and writes coef_mem in the second
    assign busy = (state_reg != S_IDLE);
    assign valid = (state_reg == S_OUT);
    assign coef_index = 4'(t_reg);
    assign coef_value = (t_reg == n_reg) ? top_reg : coef_rd_reg;
    assign last_coef = valid && (t_reg == n_reg);

    `HEC_ASSERT_IMP(a_no_start_accept_busy, clk, rst_n, valid, busy)
    `HEC_ASSERT_IMP(a_index_range, clk, rst_n, valid, coef_index <= 4'(n_reg))
    `HEC_ASSERT_NEXT(a_last_ends, clk, rst_n, last_coef, !busy)
endmodule
